FILE: rtl/ill_pkg.sv
// Shared types and constants for the integer literal lexer.
// Used by the front classifier, the queue, the scanner back end and the top level.
package ill_pkg;

  localparam int DefaultValueWidth = 64;
  localparam int DefaultQueueDepth = 4;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharOne   = 8'h31;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;
  localparam logic [7:0] CharLowX  = 8'h78;
  localparam logic [7:0] CharLowB  = 8'h62;
  localparam logic [7:0] CharDot   = 8'h2E;

  localparam logic [15:0] LenMax = 16'hFFFF;

  // Character class as seen by the scanner.
  typedef struct packed {
    logic       start;
    logic       is_zero;
    logic       dec_ok;
    logic       hex_ok;
    logic       bin_ok;
    logic       is_x;
    logic       is_b;
    logic       is_dot;
    logic [3:0] digit;
  } class_t;

  typedef enum logic [6:0] {
    PhIdle     = 7'b0000001,
    PhZero     = 7'b0000010,
    PhDec      = 7'b0000100,
    PhHexFirst = 7'b0001000,
    PhHex      = 7'b0010000,
    PhBinFirst = 7'b0100000,
    PhBin      = 7'b1000000
  } phase_e;

  // Occupancy flags of the request queue.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: rtl/ill_front.sv
// Front end of the integer literal lexer: input handshake and character classification.
// Depends on ill_pkg for the class type and character constants.
module ill_front (
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             ch_i,
  input  logic                   start_req_i,
  input  ill_pkg::queue_status_t q_status_i,
  output logic                   push_o,
  output ill_pkg::class_t        cls_o
);

  logic is_dec;
  logic is_lower_hex;
  logic is_upper_hex;

  assign in_ready_o = !q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  always_comb begin
    is_dec       = (ch_i >= ill_pkg::CharZero) && (ch_i <= ill_pkg::CharNine);
    is_lower_hex = (ch_i >= ill_pkg::CharLowA) && (ch_i <= ill_pkg::CharLowF);
    is_upper_hex = (ch_i >= ill_pkg::CharUpA) && (ch_i <= ill_pkg::CharUpF);

    cls_o.start   = start_req_i;
    cls_o.is_zero = (ch_i == ill_pkg::CharZero);
    cls_o.dec_ok  = is_dec;
    cls_o.hex_ok  = is_dec || is_lower_hex || is_upper_hex;
    cls_o.bin_ok  = (ch_i == ill_pkg::CharZero) || (ch_i == ill_pkg::CharOne);
    cls_o.is_x    = (ch_i == ill_pkg::CharLowX);
    cls_o.is_b    = (ch_i == ill_pkg::CharLowB);
    cls_o.is_dot  = (ch_i == ill_pkg::CharDot);
    // Letters a-f and A-F share their low nibble: 1..6 maps to 10..15.
    if (is_dec) begin
      cls_o.digit = ch_i[3:0];
    end else begin
      cls_o.digit = ch_i[3:0] + 4'd9;
    end
  end

endmodule

FILE: rtl/ill_queue.sv
// Small request queue between the lexer front end and the scanner back end.
// Depends on ill_pkg for the class and status types.
module ill_queue #(
  parameter int QUEUE_DEPTH = ill_pkg::DefaultQueueDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  ill_pkg::class_t        push_data_i,
  input  logic                   pop_i,
  output ill_pkg::class_t        pop_data_o,
  output ill_pkg::queue_status_t status_o
);

  localparam int PtrWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(QUEUE_DEPTH - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(QUEUE_DEPTH);

  ill_pkg::class_t entries_q [QUEUE_DEPTH];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] count_q, count_d;

  assign status_o.full  = (count_q == FullCnt);
  assign status_o.empty = (count_q == '0);
  assign pop_data_o     = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrWidth'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrWidth'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntWidth'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/ill_back.sv
// Scanner back end: literal state machine, value accumulation and result register.
// Depends on ill_pkg for the class type, phase encoding and length limit.
module ill_back #(
  parameter int VALUE_WIDTH = ill_pkg::DefaultValueWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ill_pkg::queue_status_t q_status_i,
  input  ill_pkg::class_t        cls_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   matched_o,
  output logic [VALUE_WIDTH-1:0] value_o,
  output logic [15:0]            token_length_o
);

  ill_pkg::phase_e phase_q, phase_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [15:0]            cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic                   matched_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [15:0]            len_q;

  logic                   emit;
  logic                   emit_ok;
  logic [VALUE_WIDTH-1:0] digit_ext;
  logic [VALUE_WIDTH-1:0] acc_dec;
  logic [VALUE_WIDTH-1:0] acc_hex;
  logic [VALUE_WIDTH-1:0] acc_bin;
  logic [15:0]            cnt_sat;

  assign pop_o = !q_status_i.empty && (!out_valid_q || out_ready_i);

  always_comb begin
    digit_ext = {{(VALUE_WIDTH-4){1'b0}}, cls_i.digit};
    acc_dec   = (acc_q << 3) + (acc_q << 1) + digit_ext;
    acc_hex   = (acc_q << 4) | digit_ext;
    acc_bin   = (acc_q << 1) | {{(VALUE_WIDTH-1){1'b0}}, cls_i.digit[0]};
    cnt_sat   = (cnt_q == ill_pkg::LenMax) ? cnt_q : cnt_q + 16'd1;
  end

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    emit    = 1'b0;
    emit_ok = 1'b0;
    if (cls_i.start) begin
      // A new token discards whatever was in progress.
      acc_d = '0;
      cnt_d = '0;
      if (cls_i.is_zero) begin
        cnt_d   = 16'd1;
        phase_d = ill_pkg::PhZero;
      end else if (cls_i.dec_ok) begin
        acc_d   = digit_ext;
        cnt_d   = 16'd1;
        phase_d = ill_pkg::PhDec;
      end else begin
        emit    = 1'b1;
        phase_d = ill_pkg::PhIdle;
      end
    end else begin
      unique case (phase_q)
        ill_pkg::PhIdle: begin
          phase_d = ill_pkg::PhIdle;
        end
        ill_pkg::PhZero: begin
          if (cls_i.is_x) begin
            cnt_d   = cnt_q + 16'd1;
            phase_d = ill_pkg::PhHexFirst;
          end else if (cls_i.is_b) begin
            cnt_d   = cnt_q + 16'd1;
            phase_d = ill_pkg::PhBinFirst;
          end else if (cls_i.dec_ok) begin
            acc_d   = acc_dec;
            cnt_d   = cnt_sat;
            phase_d = ill_pkg::PhDec;
          end else begin
            emit    = 1'b1;
            emit_ok = 1'b1;
          end
        end
        ill_pkg::PhDec: begin
          if (cls_i.dec_ok) begin
            acc_d = acc_dec;
            cnt_d = cnt_sat;
          end else begin
            emit    = 1'b1;
            emit_ok = !cls_i.is_dot;
          end
        end
        ill_pkg::PhHexFirst, ill_pkg::PhHex: begin
          if (cls_i.hex_ok) begin
            acc_d   = acc_hex;
            cnt_d   = cnt_sat;
            phase_d = ill_pkg::PhHex;
          end else begin
            emit    = 1'b1;
            emit_ok = (phase_q == ill_pkg::PhHex);
          end
        end
        ill_pkg::PhBinFirst, ill_pkg::PhBin: begin
          if (cls_i.bin_ok) begin
            acc_d   = acc_bin;
            cnt_d   = cnt_sat;
            phase_d = ill_pkg::PhBin;
          end else begin
            emit    = 1'b1;
            emit_ok = (phase_q == ill_pkg::PhBin);
          end
        end
        default: begin
          phase_d = ill_pkg::PhIdle;
        end
      endcase
      if (emit) begin
        phase_d = ill_pkg::PhIdle;
        acc_d   = '0;
        cnt_d   = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ill_pkg::PhIdle;
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      matched_q <= emit_ok;
      value_q   <= emit_ok ? acc_q : '0;
      len_q     <= emit_ok ? cnt_q : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign matched_o      = matched_q;
  assign value_o        = value_q;
  assign token_length_o = len_q;

endmodule

FILE: rtl/integer_literal_lexer.sv
// Integer literal lexer top level: front classifier, request queue and scanner back end.
// Depends on ill_pkg, ill_front, ill_queue and ill_back.

// The lexer takes one character per cycle while the queue has room and recognizes decimal,
// 0x hexadecimal and 0b binary integer literals; each finished token gives one result with a
// match flag, the value modulo 2^VALUE_WIDTH and the saturating length. A start request on
// a character that is not a decimal digit gives a rejected result, and a character that
// neither starts nor extends a token gives none. A character is classified and written into
// the queue when it is accepted; the scanner pops it into its state registers, and a
// terminating character writes its result to the output register when popped. The rate is
// set by the scanner's single shift-add accumulation per character; the queue of QUEUE_DEPTH
// requests and the output register let input and output stall independently.
module integer_literal_lexer #(
  parameter int VALUE_WIDTH = ill_pkg::DefaultValueWidth,
  parameter int QUEUE_DEPTH = ill_pkg::DefaultQueueDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             ch_i,
  input  logic                   start_req_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   matched_o,
  output logic [VALUE_WIDTH-1:0] value_o,
  output logic [15:0]            token_length_o
);

  ill_pkg::queue_status_t q_status;
  ill_pkg::class_t        push_cls;
  ill_pkg::class_t        pop_cls;
  logic                   push;
  logic                   pop;

  ill_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .ch_i        (ch_i),
    .start_req_i (start_req_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .cls_o       (push_cls)
  );

  ill_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cls),
    .pop_i       (pop),
    .pop_data_o  (pop_cls),
    .status_o    (q_status)
  );

  ill_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .cls_i          (pop_cls),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .matched_o      (matched_o),
    .value_o        (value_o),
    .token_length_o (token_length_o)
  );

`ifndef SYNTHESIS
  // A held result must block the scanner, or the next result would overwrite it.
  a_no_pop_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !pop)
    else $error("scanner consumed a request while the result register was held");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("scanner consumed a request from an empty queue");

  a_reject_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !matched_o) |-> (value_o == '0 && token_length_o == 16'd0))
    else $error("rejected token carries a nonzero value or length");
`endif

endmodule
